@@ sv/i2a_pkg.sv @@
`timescale 1ns / 1ps

package i2a_pkg;

    // Format selector codes; the spare code formats like unsigned decimal
    typedef enum logic [1:0] {
        CMD_SDEC = 2'd0,
        CMD_SHEX = 2'd1,
        CMD_UDEC = 2'd2
    } t_cmd;

    localparam int WORD_W    = 32;
    localparam int DEC_DIGS  = 10;
    localparam int BCD_W     = 4 * DEC_DIGS;
    localparam int BITS_STG  = 4;
    localparam int N_STAGES  = WORD_W / BITS_STG;
    localparam int IDX_W     = 4;
    localparam int CHAR_W    = 7;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
    localparam logic [CHAR_W-1:0] CH_HEXA  = 7'h37;

    // Request as it moves down the conversion pipeline
    typedef struct packed {
        logic              hex;
        logic              neg;
        logic              comma;
        logic [WORD_W-1:0] mag;
        logic [BCD_W-1:0]  bcd;
    } t_conv_req;

    // Serializer sequence
    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_X,
        S_MINUS,
        S_DIGIT,
        S_COMMA
    } t_state;

    // Digit value to uppercase ASCII
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {3'b000, d};
        if (d < 4'd10) begin
            digit_char = CH_ZERO + ext;
        end else begin
            digit_char = CH_HEXA + ext;
        end
    endfunction

endpackage

@@ sv/i2a_in_if.sv @@
`timescale 1ns / 1ps

interface i2a_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

@@ sv/i2a_out_if.sv @@
`timescale 1ns / 1ps

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ sv/integer_to_ascii_formatter_top.sv @@
`timescale 1ns / 1ps
// Integer to ASCII formatter.
// Input channel i_in (valid/ready) carries cmd and a 32-bit value; cmd 0 is
// signed decimal, 1 signed hex with "0x" prefix, 2 (and 3) unsigned decimal
// with a trailing comma. Output channel o_out (valid/ready) returns the text
// one ASCII character per transfer, most significant digit first, with
// last_char set on the final character.
// Path of a request: one input register, eight double-dabble stages of four
// bits each, the serializer and the output register.
// Throughput: one character per cycle while the receiver holds ready high; a
// value is 1 to 11 characters long. The next value is loaded in the cycle its
// predecessor's final character enters the output register, and up to nine
// values wait in the conversion pipeline meanwhile.
// Reset (synchronous, active low) empties the pipeline and the output.
// When the receiver holds ready low, the output character holds and the
// pipeline fills and then stops taking input; nothing is lost or repeated.
module integer_to_ascii_formatter_top import i2a_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    i2a_in_if.sink     i_in,
    i2a_out_if.source  o_out
);

    logic      r_in_valid;
    t_conv_req r_in_data;
    t_conv_req n_in_data;
    logic      in_ready;
    logic      neg;

    logic      stg_valid [N_STAGES+1];
    logic      stg_ready [N_STAGES+1];
    t_conv_req stg_data  [N_STAGES+1];

    // Decode format and take the magnitude
    always_comb begin
        n_in_data       = '0;
        neg             = 1'b0;
        case (t_cmd'(i_in.cmd))
            CMD_SDEC: neg = i_in.value[WORD_W-1];
            CMD_SHEX: begin
                neg           = i_in.value[WORD_W-1];
                n_in_data.hex = 1'b1;
            end
            default:  n_in_data.comma = 1'b1;
        endcase
        n_in_data.neg = neg;
        n_in_data.mag = neg ? (~i_in.value + 1'b1) : i_in.value;
    end

    assign in_ready   = !r_in_valid || stg_ready[0];
    assign i_in.ready = in_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_data <= n_in_data;
        end
    end

    assign stg_valid[0] = r_in_valid;
    assign stg_data[0]  = r_in_data;

    // Binary to BCD pipeline
    for (genvar g = 0; g < N_STAGES; g++) begin : g_bcd
        i2a_bcd_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    // Character sequencer and output register
    i2a_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stg_valid[N_STAGES]),
        .o_ready (stg_ready[N_STAGES]),
        .i_data  (stg_data[N_STAGES]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_char  (o_out.char_code),
        .o_last  (o_out.last_char)
    );

endmodule

@@ sv/i2a_bcd_stage.sv @@
`timescale 1ns / 1ps

module i2a_bcd_stage import i2a_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_conv_req i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_conv_req o_data
);

    logic      r_valid;
    t_conv_req r_data;
    t_conv_req n_data;
    logic [BCD_W-1:0]  bcd;
    logic [WORD_W-1:0] mag;

    // Four double-dabble steps: add 3 to digits >= 5, then shift in the next bit (skipped for hex)
    always_comb begin
        bcd = i_data.bcd;
        mag = i_data.mag;
        if (!i_data.hex) begin
            for (int j = 0; j < BITS_STG; j++) begin
                for (int k = 0; k < DEC_DIGS; k++) begin
                    if (bcd[4*k +: 4] >= 4'd5) begin
                        bcd[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
                    end
                end
                bcd = {bcd[BCD_W-2:0], mag[WORD_W-1]};
                mag = {mag[WORD_W-2:0], 1'b0};
            end
        end
        n_data     = i_data;
        n_data.bcd = bcd;
        n_data.mag = mag;
    end

    assign o_ready = !r_valid || i_ready;

    // Stage register, holds while downstream stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_data))
        else $error("stage lost or changed a stalled request");
    a_hex_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && i_valid && i_data.hex |=> r_data.mag == $past(i_data.mag))
        else $error("hex request was modified by conversion stage");
`endif

endmodule

@@ sv/i2a_serializer.sv @@
`timescale 1ns / 1ps

module i2a_serializer import i2a_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_conv_req         i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_last
);

    t_state            r_state;
    t_state            n_state;
    t_state            first_state;
    logic              r_hex;
    logic              r_neg;
    logic              r_comma;
    logic [BCD_W-1:0]  r_digits;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic              out_free;
    logic              emit;
    logic              load;
    logic              cur_last;
    logic [CHAR_W-1:0] cur_char;
    logic [BCD_W-1:0]  ld_digits;
    logic [IDX_W-1:0]  ld_lead;

    // Digits of the incoming request and index of its leading digit
    always_comb begin
        ld_digits = i_data.hex ? {{(BCD_W-WORD_W){1'b0}}, i_data.mag} : i_data.bcd;
        ld_lead   = '0;
        for (int i = 0; i < DEC_DIGS; i++) begin
            if (ld_digits[4*i +: 4] != 4'd0) begin
                ld_lead = IDX_W'(i);
            end
        end
        if (i_data.hex) begin
            first_state = S_ZERO;
        end else if (i_data.neg) begin
            first_state = S_MINUS;
        end else begin
            first_state = S_DIGIT;
        end
    end

    // Outputs of the sequence
    always_comb begin
        cur_char = CH_ZERO;
        cur_last = 1'b0;
        case (r_state)
            S_ZERO:  cur_char = CH_ZERO;
            S_X:     cur_char = CH_X;
            S_MINUS: cur_char = CH_MINUS;
            S_DIGIT: begin
                cur_char = digit_char(r_digits[{r_idx, 2'b00} +: 4]);
                cur_last = (r_idx == '0) && !r_comma;
            end
            S_COMMA: begin
                cur_char = CH_COMMA;
                cur_last = 1'b1;
            end
            default: cur_char = CH_ZERO;
        endcase
        out_free = !r_out_valid || i_ready;
        emit     = (r_state != S_IDLE) && out_free;
        o_ready  = (r_state == S_IDLE) || (emit && cur_last);
        load     = i_valid && o_ready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        if (emit) begin
            case (r_state)
                S_ZERO:  n_state = S_X;
                S_X:     n_state = r_neg ? S_MINUS : S_DIGIT;
                S_MINUS: n_state = S_DIGIT;
                S_DIGIT: begin
                    if (r_idx != '0) begin
                        n_idx = r_idx - 1'b1;
                    end else begin
                        n_state = r_comma ? S_COMMA : S_IDLE;
                    end
                end
                S_COMMA: n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
        if (load) begin
            n_state = first_state;
            n_idx   = ld_lead;
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // Request payload and output register
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (load) begin
            r_hex    <= i_data.hex;
            r_neg    <= i_data.neg;
            r_comma  <= i_data.comma;
            r_digits <= ld_digits;
        end
        if (emit) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIGIT |-> (r_idx < IDX_W'(DEC_DIGS)) && (!r_hex || r_idx < 4'd8))
        else $error("digit index out of range");
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && cur_last && !load |=> r_state == S_IDLE)
        else $error("sequence did not end after final character");
    a_comma_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_char == CH_COMMA |-> r_out_last)
        else $error("comma emitted without final flag");
`endif

endmodule
